FILE: rtl/core/assert_macros.svh
// Assertion macros used by elf64_image_validator_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside of reset.
`define EV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// The condition must never be true outside of reset.
`define EV_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define EV_ASSERT(lbl, clk, rstn, prop, msg)
`define EV_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/core/elfval_pkg.sv
`default_nettype none

package elfval_pkg;

    localparam logic [63:0] PAGE_SIZE = 64'd4096;
    localparam logic [63:0] PAGE_MASK = PAGE_SIZE - 64'd1;

    localparam logic [47:0] IDENT_ELF64    = 48'h0102_464c_457f;
    localparam logic [31:0] TYPE_EXEC      = 32'd2;
    localparam logic [15:0] MACHINE_X86_64 = 16'd62;
    localparam logic [15:0] PHDR_BYTES     = 16'd56;
    localparam logic [63:0] HEADER_BYTES   = 64'd64;
    localparam logic [31:0] SEG_LOAD       = 32'd1;
    localparam logic [63:0] LOW12_MASK     = 64'hfff;

    localparam logic [63:0] WINDOW_LOW_RESET  = 64'h40_0000;
    localparam logic [63:0] WINDOW_HIGH_RESET = 64'h80_0000;

    localparam logic CFG_WINDOW_LOW  = 1'b0;
    localparam logic CFG_WINDOW_HIGH = 1'b1;

    typedef enum logic [1:0] {
        FUNC_HEADER  = 2'd0,
        FUNC_SEGMENT = 2'd1,
        FUNC_FINISH  = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_OPEN   = 2'd1,
        PH_FAILED = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_BAD_HEADER  = 3'd1,
        ST_BAD_SEGMENT = 3'd2,
        ST_BAD_RANGE   = 3'd3,
        ST_IMAGE_VALID = 3'd4,
        ST_REJECTED    = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] ident_bytes;
        logic [31:0] type_code;
        logic [15:0] machine_code;
        logic [15:0] entry_size;
        logic [15:0] entry_count;
        logic [63:0] offset_value;
        logic [63:0] address_value;
        logic [63:0] size_value;
        logic [63:0] memory_size;
        logic [63:0] alignment;
    } item_t;

    typedef struct packed {
        logic [63:0] file_length;
        logic [63:0] entry_point;
        logic [63:0] lowest_address;
        logic [63:0] highest_address;
        phase_t      phase;
    } ctx_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] load_base;
        logic [63:0] load_span;
        logic [63:0] entry_address;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/elfval_eval.sv
`default_nettype none

module elfval_eval (
    input  elfval_pkg::item_t   item,
    input  elfval_pkg::ctx_t    ctx,
    input  logic [63:0]         window_low,
    input  logic [63:0]         window_high,
    output elfval_pkg::ctx_t    ctx_next,
    output elfval_pkg::result_t result,
    output logic                has_result
);

    logic [21:0] table_bytes;
    logic [64:0] table_end;
    logic        header_pass;
    logic [64:0] file_end;
    logic [64:0] seg_end;
    logic        segment_pass;
    logic [63:0] page_rem;
    logic [64:0] round_up;
    logic [63:0] span_end;
    logic [63:0] base_addr;
    logic        finish_pass;

    always_comb begin
        table_bytes = 22'(item.entry_count) * 22'(elfval_pkg::PHDR_BYTES);
        table_end   = {1'b0, item.offset_value} + 65'(table_bytes);
        header_pass = (item.ident_bytes == elfval_pkg::IDENT_ELF64)
                   && (item.type_code == elfval_pkg::TYPE_EXEC)
                   && (item.machine_code == elfval_pkg::MACHINE_X86_64)
                   && (item.entry_size == elfval_pkg::PHDR_BYTES)
                   && (item.size_value >= elfval_pkg::HEADER_BYTES)
                   && (table_end <= {1'b0, item.size_value});

        file_end = {1'b0, item.offset_value} + {1'b0, item.size_value};
        seg_end  = {1'b0, item.address_value} + {1'b0, item.memory_size};
        segment_pass = (item.size_value <= item.memory_size)
                    && (file_end <= {1'b0, ctx.file_length})
                    && (item.address_value >= window_low)
                    && (seg_end <= {1'b0, window_high})
                    && (item.alignment >= elfval_pkg::PAGE_SIZE)
                    && ((item.address_value & elfval_pkg::LOW12_MASK)
                        == (item.offset_value & elfval_pkg::LOW12_MASK));

        page_rem  = ctx.highest_address & elfval_pkg::PAGE_MASK;
        round_up  = {1'b0, ctx.highest_address} + {1'b0, elfval_pkg::PAGE_SIZE - page_rem};
        span_end  = (page_rem == 64'd0) ? ctx.highest_address : round_up[63:0];
        base_addr = ctx.lowest_address & ~elfval_pkg::PAGE_MASK;
        finish_pass = (ctx.lowest_address < ctx.highest_address)
                   && (ctx.entry_point >= ctx.lowest_address)
                   && (ctx.entry_point < ctx.highest_address)
                   && ((page_rem == 64'd0) || !round_up[64]);

        ctx_next             = ctx;
        result.status        = elfval_pkg::ST_ACCEPTED;
        result.load_base     = 64'd0;
        result.load_span     = 64'd0;
        result.entry_address = 64'd0;
        has_result           = 1'b1;

        case (elfval_pkg::func_t'(item.func))
            elfval_pkg::FUNC_HEADER: begin
                ctx_next.file_length     = item.size_value;
                ctx_next.entry_point     = item.address_value;
                ctx_next.lowest_address  = window_high;
                ctx_next.highest_address = 64'd0;
                if (header_pass) begin
                    ctx_next.phase = elfval_pkg::PH_OPEN;
                end else begin
                    ctx_next.phase = elfval_pkg::PH_FAILED;
                    result.status  = elfval_pkg::ST_BAD_HEADER;
                end
            end
            elfval_pkg::FUNC_SEGMENT, elfval_pkg::FUNC_FINISH: begin
                if (ctx.phase != elfval_pkg::PH_OPEN) begin
                    result.status = elfval_pkg::ST_REJECTED;
                end else if (item.func == elfval_pkg::FUNC_SEGMENT) begin
                    if (item.type_code == elfval_pkg::SEG_LOAD) begin
                        if (!segment_pass) begin
                            ctx_next.phase = elfval_pkg::PH_FAILED;
                            result.status  = elfval_pkg::ST_BAD_SEGMENT;
                        end else begin
                            if (item.address_value < ctx.lowest_address) begin
                                ctx_next.lowest_address = item.address_value;
                            end
                            if (seg_end[63:0] > ctx.highest_address) begin
                                ctx_next.highest_address = seg_end[63:0];
                            end
                        end
                    end
                end else begin
                    if (!finish_pass) begin
                        ctx_next.phase = elfval_pkg::PH_FAILED;
                        result.status  = elfval_pkg::ST_BAD_RANGE;
                    end else begin
                        ctx_next.phase       = elfval_pkg::PH_IDLE;
                        result.status        = elfval_pkg::ST_IMAGE_VALID;
                        result.load_base     = base_addr;
                        result.load_span     = span_end - base_addr;
                        result.entry_address = ctx.entry_point;
                    end
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/elf64_image_validator_core.sv
// ELF64 image validator.
// Requests arrive on the s_ channel (valid/ready): a file header, then program
// headers, then a finish request. Each request except the unused selector code
// gives exactly one result on the m_ channel (valid/ready) with a status and,
// for a valid image, the page-aligned base, the page-rounded size and the entry.
// A request is captured in an input register and evaluated from there into a
// result register that drives m_valid; one request per cycle is sustained
// while the receiver keeps m_ready high. The window registers are written
// through cfg_we, cfg_index and cfg_wdata; the user must write them only while
// no request is in flight, which the block does not enforce, and they then take
// effect on the next request.
// When the receiver holds m_ready low, the result register holds its result,
// one more request is still captured in the input register, and s_ready then
// drops until the result is taken. A request with the unused selector code is
// consumed without a result even while the output is stalled.
// Synchronous reset clears both registers' valid flags, sets the window to its
// default values and returns the image state to idle with no header seen.
`default_nettype none
`include "assert_macros.svh"

module elf64_image_validator_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [63:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_func,
    input  wire  [47:0] s_ident_bytes,
    input  wire  [31:0] s_type_code,
    input  wire  [15:0] s_machine_code,
    input  wire  [15:0] s_entry_size,
    input  wire  [15:0] s_entry_count,
    input  wire  [63:0] s_offset_value,
    input  wire  [63:0] s_address_value,
    input  wire  [63:0] s_size_value,
    input  wire  [63:0] s_memory_size,
    input  wire  [63:0] s_alignment,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_load_base,
    output logic [63:0] m_load_span,
    output logic [63:0] m_entry_address
);

    logic                in_valid_reg;
    elfval_pkg::item_t   in_item_reg;
    logic                out_valid_reg;
    elfval_pkg::result_t out_result_reg;
    elfval_pkg::ctx_t    ctx_reg;
    elfval_pkg::ctx_t    ctx_next;
    logic [63:0]         window_low_reg;
    logic [63:0]         window_high_reg;
    elfval_pkg::result_t eval_result;
    logic                eval_has_result;
    logic                out_free;
    logic                advance;
    logic                s_fire;

    elfval_eval u_eval (
        .item        (in_item_reg),
        .ctx         (ctx_reg),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .ctx_next    (ctx_next),
        .result      (eval_result),
        .has_result  (eval_has_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (out_free || !eval_has_result);
    assign s_ready  = !in_valid_reg || advance;
    assign s_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            window_low_reg  <= elfval_pkg::WINDOW_LOW_RESET;
            window_high_reg <= elfval_pkg::WINDOW_HIGH_RESET;
            ctx_reg.file_length     <= 64'd0;
            ctx_reg.entry_point     <= 64'd0;
            ctx_reg.lowest_address  <= elfval_pkg::WINDOW_HIGH_RESET;
            ctx_reg.highest_address <= 64'd0;
            ctx_reg.phase           <= elfval_pkg::PH_IDLE;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    elfval_pkg::CFG_WINDOW_LOW:  window_low_reg  <= cfg_wdata;
                    elfval_pkg::CFG_WINDOW_HIGH: window_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                ctx_reg <= ctx_next;
            end
            if (advance && eval_has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.func          <= s_func;
            in_item_reg.ident_bytes   <= s_ident_bytes;
            in_item_reg.type_code     <= s_type_code;
            in_item_reg.machine_code  <= s_machine_code;
            in_item_reg.entry_size    <= s_entry_size;
            in_item_reg.entry_count   <= s_entry_count;
            in_item_reg.offset_value  <= s_offset_value;
            in_item_reg.address_value <= s_address_value;
            in_item_reg.size_value    <= s_size_value;
            in_item_reg.memory_size   <= s_memory_size;
            in_item_reg.alignment     <= s_alignment;
        end
        if (advance && eval_has_result) begin
            out_result_reg <= eval_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_result_reg.status;
    assign m_load_base     = out_result_reg.load_base;
    assign m_load_span     = out_result_reg.load_span;
    assign m_entry_address = out_result_reg.entry_address;

    `EV_ASSERT(a_base_aligned, aclk, aresetn, (m_valid && m_status == elfval_pkg::ST_IMAGE_VALID) |-> ((m_load_base & elfval_pkg::PAGE_MASK) == 64'd0), "image base is not page aligned")
    `EV_ASSERT(a_fields_zero, aclk, aresetn, (m_valid && m_status != elfval_pkg::ST_IMAGE_VALID) |-> (m_load_base == 64'd0 && m_load_span == 64'd0 && m_entry_address == 64'd0), "image fields set without a valid image")
    `EV_ASSERT(a_valid_to_idle, aclk, aresetn, (advance && eval_has_result && eval_result.status == elfval_pkg::ST_IMAGE_VALID) |=> (ctx_reg.phase == elfval_pkg::PH_IDLE), "phase not idle after a valid image")
    `EV_NEVER(a_result_overrun, aclk, aresetn, advance && eval_has_result && out_valid_reg && !m_ready, "result register overwritten while stalled")

endmodule

`default_nettype wire

FILE: sim/elf64_image_validator_core_tb.sv
`timescale 1ns / 100ps

module elf64_image_validator_core_tb;
    import elfval_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;

    typedef enum int {
        FLAW_NONE,
        FLAW_IDENT,
        FLAW_TYPE,
        FLAW_MACHINE,
        FLAW_ENTSIZE,
        FLAW_SHORT_FILE,
        FLAW_TABLE,
        FLAW_TABLE_WRAP,
        FLAW_FILESZ,
        FLAW_FILE_END,
        FLAW_OFF_WRAP,
        FLAW_BELOW_WINDOW,
        FLAW_ABOVE_WINDOW,
        FLAW_ADDR_WRAP,
        FLAW_ALIGN,
        FLAW_CONGRUENCE,
        FLAW_ENTRY,
        FLAW_NO_HEADER,
        FLAW_NO_FINISH,
        FLAW_EXTRA_FINISH,
        FLAW_SELECTOR
    } flaw_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_WINDOW_LOW;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_HEADER;
    logic [47:0] s_ident_bytes = '0;
    logic [31:0] s_type_code = '0;
    logic [15:0] s_machine_code = '0;
    logic [15:0] s_entry_size = '0;
    logic [15:0] s_entry_count = '0;
    logic [63:0] s_offset_value = '0;
    logic [63:0] s_address_value = '0;
    logic [63:0] s_size_value = '0;
    logic [63:0] s_memory_size = '0;
    logic [63:0] s_alignment = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [63:0] m_load_base;
    logic [63:0] m_load_span;
    logic [63:0] m_entry_address;

    elf64_image_validator_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_ident_bytes   (s_ident_bytes),
        .s_type_code     (s_type_code),
        .s_machine_code  (s_machine_code),
        .s_entry_size    (s_entry_size),
        .s_entry_count   (s_entry_count),
        .s_offset_value  (s_offset_value),
        .s_address_value (s_address_value),
        .s_size_value    (s_size_value),
        .s_memory_size   (s_memory_size),
        .s_alignment     (s_alignment),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_load_base     (m_load_base),
        .m_load_span     (m_load_span),
        .m_entry_address (m_entry_address)
    );

    always #5 aclk = ~aclk;

    item_t       pending_reqs[$];
    result_t     expected_verdicts[$];
    item_t       cur_req;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_requests = 0;
    int          rx_hold_seen = 0;
    int          rx_hold_left = 0;
    int          error_count = 0;
    int          stim_count = 0;

    logic [63:0] win_lo = WINDOW_LOW_RESET;
    logic [63:0] win_hi = WINDOW_HIGH_RESET;
    logic [63:0] img_file_len = '0;
    logic [63:0] img_entry = '0;
    logic [63:0] img_lowest = WINDOW_HIGH_RESET;
    logic [63:0] img_highest = '0;
    phase_t      img_phase = PH_IDLE;

    function automatic result_t predict_verdict(item_t req);
        result_t     res;
        logic [64:0] file_end;
        logic [64:0] mem_end;
        logic [64:0] table_end;
        logic [64:0] rounded;
        logic [63:0] rem;
        logic [63:0] up;
        logic        ok;
        res = '0;
        res.status = ST_ACCEPTED;
        if (req.func == FUNC_HEADER) begin
            img_file_len = req.size_value;
            img_entry = req.address_value;
            img_lowest = win_hi;
            img_highest = '0;
            table_end = {1'b0, req.offset_value} + 65'(req.entry_count) * 65'(PHDR_BYTES);
            ok = req.ident_bytes == IDENT_ELF64 && req.type_code == TYPE_EXEC &&
                 req.machine_code == MACHINE_X86_64 && req.entry_size == PHDR_BYTES &&
                 req.size_value >= HEADER_BYTES && !table_end[64] &&
                 table_end[63:0] <= req.size_value;
            img_phase = ok ? PH_OPEN : PH_FAILED;
            res.status = ok ? ST_ACCEPTED : ST_BAD_HEADER;
        end else if (img_phase != PH_OPEN) begin
            res.status = ST_REJECTED;
        end else if (req.func == FUNC_SEGMENT) begin
            if (req.type_code == SEG_LOAD) begin
                file_end = {1'b0, req.offset_value} + {1'b0, req.size_value};
                mem_end = {1'b0, req.address_value} + {1'b0, req.memory_size};
                ok = req.size_value <= req.memory_size && !file_end[64] &&
                     file_end[63:0] <= img_file_len && req.address_value >= win_lo &&
                     !mem_end[64] && mem_end[63:0] <= win_hi && req.alignment >= PAGE_SIZE &&
                     (req.address_value & LOW12_MASK) == (req.offset_value & LOW12_MASK);
                if (!ok) begin
                    img_phase = PH_FAILED;
                    res.status = ST_BAD_SEGMENT;
                end else begin
                    if (req.address_value < img_lowest) img_lowest = req.address_value;
                    if (mem_end[63:0] > img_highest) img_highest = mem_end[63:0];
                end
            end
        end else begin
            rem = img_highest % PAGE_SIZE;
            up = img_highest;
            ok = img_lowest < img_highest && img_entry >= img_lowest && img_entry < img_highest;
            if (ok && rem != 0) begin
                rounded = {1'b0, img_highest} + {1'b0, PAGE_SIZE - rem};
                ok = !rounded[64];
                up = rounded[63:0];
            end
            if (!ok) begin
                img_phase = PH_FAILED;
                res.status = ST_BAD_RANGE;
            end else begin
                res.load_base = img_lowest - img_lowest % PAGE_SIZE;
                res.load_span = up - res.load_base;
                res.entry_address = img_entry;
                img_phase = PH_IDLE;
                res.status = ST_IMAGE_VALID;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready && cur_req.func != FUNC_NONE) begin
                expected_verdicts.push_back(predict_verdict(cur_req));
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_func <= cur_req.func;
                    s_ident_bytes <= cur_req.ident_bytes;
                    s_type_code <= cur_req.type_code;
                    s_machine_code <= cur_req.machine_code;
                    s_entry_size <= cur_req.entry_size;
                    s_entry_count <= cur_req.entry_count;
                    s_offset_value <= cur_req.offset_value;
                    s_address_value <= cur_req.address_value;
                    s_size_value <= cur_req.size_value;
                    s_memory_size <= cur_req.memory_size;
                    s_alignment <= cur_req.alignment;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result with status %0d", m_status);
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        error_count++;
                    end
                    if (m_load_base !== want.load_base) begin
                        $error("load_base: expected %h, got %h", want.load_base, m_load_base);
                        error_count++;
                    end
                    if (m_load_span !== want.load_span) begin
                        $error("load_span: expected %h, got %h", want.load_span, m_load_span);
                        error_count++;
                    end
                    if (m_entry_address !== want.entry_address) begin
                        $error("entry_address: expected %h, got %h",
                               want.entry_address, m_entry_address);
                        error_count++;
                    end
                end
            end
            if (rx_hold_seen != rx_hold_requests) begin
                rx_hold_seen = rx_hold_requests;
                rx_hold_left = RX_HOLD_CYCLES;
            end else if (rx_hold_left != 0) begin
                rx_hold_left--;
            end
            m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t random_req();
        item_t req;
        req.func = 2'($urandom_range(3));
        req.ident_bytes = 48'(rand64());
        req.type_code = $urandom;
        req.machine_code = 16'($urandom);
        req.entry_size = 16'($urandom);
        req.entry_count = 16'($urandom);
        req.offset_value = rand64();
        req.address_value = rand64();
        req.size_value = rand64();
        req.memory_size = rand64();
        req.alignment = rand64();
        return req;
    endfunction

    function automatic item_t header_req(logic [47:0] ident, logic [31:0] etype,
                                         logic [15:0] mach, logic [15:0] esz,
                                         logic [15:0] cnt, logic [63:0] toff,
                                         logic [63:0] entry, logic [63:0] flen);
        item_t req;
        req = random_req();
        req.func = FUNC_HEADER;
        req.ident_bytes = ident;
        req.type_code = etype;
        req.machine_code = mach;
        req.entry_size = esz;
        req.entry_count = cnt;
        req.offset_value = toff;
        req.address_value = entry;
        req.size_value = flen;
        return req;
    endfunction

    function automatic item_t segment_req(logic [31:0] stype, logic [63:0] off,
                                          logic [63:0] vaddr, logic [63:0] filesz,
                                          logic [63:0] memsz, logic [63:0] align);
        item_t req;
        req = random_req();
        req.func = FUNC_SEGMENT;
        req.type_code = stype;
        req.offset_value = off;
        req.address_value = vaddr;
        req.size_value = filesz;
        req.memory_size = memsz;
        req.alignment = align;
        return req;
    endfunction

    function automatic item_t finish_req();
        item_t req;
        req = random_req();
        req.func = FUNC_FINISH;
        return req;
    endfunction

    function automatic item_t selector_req();
        item_t req;
        req = random_req();
        req.func = FUNC_NONE;
        return req;
    endfunction

    task automatic push_req(item_t req);
        pending_reqs.push_back(req);
        if (req.func != FUNC_NONE) stim_count++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_window(logic [63:0] lo, logic [63:0] hi);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WINDOW_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_WINDOW_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we <= 1'b0;
        win_lo = lo;
        win_hi = hi;
        @(negedge aclk);
    endtask

    task automatic queue_directed();
        push_req(finish_req());
        push_req(segment_req(SEG_LOAD, 64'h0, 64'h40_0000, 64'h10, 64'h10, 64'h1000));
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd3,
                            HEADER_BYTES, 64'h40_1000, 64'h1_0000));
        push_req(segment_req(32'd6, rand64(), rand64(), rand64(), rand64(), rand64()));
        push_req(segment_req(SEG_LOAD, 64'h1000, 64'h40_0000, 64'h800, 64'h1000, 64'h1000));
        push_req(segment_req(SEG_LOAD, 64'h2010, 64'h7f_f010, 64'h0, 64'hff0, 64'h20_0000));
        push_req(finish_req());
        push_req(finish_req());
        push_req(header_req('0, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd1,
                            HEADER_BYTES, 64'h40_0000, 64'h1000));
        push_req(segment_req(SEG_LOAD, 64'h0, 64'h40_0000, 64'h10, 64'h10, 64'h1000));
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd0,
                            HEADER_BYTES, 64'h40_0000, 64'd63));
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd1,
                            '1, 64'h40_0000, 64'h1000));
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd1,
                            HEADER_BYTES, 64'h40_0100, 64'h1_0000));
        push_req(segment_req(SEG_LOAD, 64'h0, 64'h40_0000, 64'h2000, 64'h1000, 64'h1000));
        push_req(finish_req());
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd1,
                            HEADER_BYTES, 64'h50_0000, 64'h1_0000));
        push_req(segment_req(SEG_LOAD, 64'h0, 64'h40_0000, 64'h100, 64'h100, 64'h1000));
        push_req(finish_req());
        push_req(selector_req());
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd1,
                            HEADER_BYTES, 64'h40_0010, 64'h1_0000));
        push_req(segment_req(SEG_LOAD, 64'h10, 64'h40_0010, 64'h10, 64'h10, 64'hfff));
        push_req(segment_req(SEG_LOAD, 64'h11, 64'h40_0010, 64'h10, 64'h10, 64'h1000));
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'hffff,
                            HEADER_BYTES, 64'h40_0000, '1));
        push_req(finish_req());
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'hffff,
                            HEADER_BYTES, 64'h40_0000, '1));
        push_req(segment_req(SEG_LOAD, 64'h0, 64'h40_0000, 64'h1, 64'h1, 64'h1 << 63));
        push_req(finish_req());
    endtask

    task automatic queue_image();
        item_t       segs[$];
        int          load_idx[$];
        item_t       seg;
        item_t       hdr;
        flaw_t       flaw;
        logic [63:0] span, vaddr, room, cap, memsz, filesz, off, seg_end;
        logic [63:0] lo, hi, entry, file_len, need;
        logic [15:0] cnt;
        int          nload, bad_idx, sel_idx, i;
        nload = $urandom_range(1, 6);
        flaw = FLAW_NONE;
        if ($urandom_range(99) < 30) flaw = flaw_t'($urandom_range(FLAW_IDENT, FLAW_SELECTOR));
        span = (win_hi > win_lo) ? win_hi - win_lo : 64'd1;
        lo = '1;
        hi = '0;
        need = '0;
        for (i = 0; i < nload; i++) begin
            if ($urandom_range(3) == 0) begin
                seg = segment_req($urandom, rand64(), rand64(), rand64(), rand64(), rand64());
                if (seg.type_code == SEG_LOAD) seg.type_code = '0;
                segs.push_back(seg);
            end
            vaddr = win_lo + rand64() % span;
            room = win_hi - vaddr;
            cap = (room < 64'h10_0000) ? room : 64'h10_0000;
            case ($urandom_range(15))
                0: memsz = '0;
                1: memsz = room;
                default: memsz = (cap == 0) ? 64'd0 : 64'd1 + rand64() % cap;
            endcase
            filesz = rand64() % (((memsz < 64'h1_0000) ? memsz : 64'h1_0000) + 64'd1);
            off = (64'($urandom_range(255)) << 12) | (vaddr & LOW12_MASK);
            if (off + filesz > need) need = off + filesz;
            if (vaddr < lo) lo = vaddr;
            seg_end = vaddr + memsz;
            if (seg_end > hi) hi = seg_end;
            load_idx.push_back(segs.size());
            segs.push_back(segment_req(SEG_LOAD, off, vaddr, filesz, memsz,
                                       PAGE_SIZE << $urandom_range(8)));
        end
        cnt = 16'(segs.size());
        file_len = HEADER_BYTES + 64'(cnt) * 56;
        if (need > file_len) file_len = need;
        file_len = file_len + $urandom_range(4096);
        entry = (hi > lo) ? lo + rand64() % (hi - lo) : lo;

        bad_idx = load_idx[$urandom_range(load_idx.size() - 1)];
        seg = segs[bad_idx];
        case (flaw)
            FLAW_FILESZ: seg.size_value = seg.memory_size + 64'd1 + $urandom_range(255);
            FLAW_FILE_END: seg.offset_value = ((file_len + PAGE_SIZE) & ~LOW12_MASK) |
                                              (seg.address_value & LOW12_MASK);
            FLAW_OFF_WRAP: begin
                seg.offset_value = ~LOW12_MASK | (seg.address_value & LOW12_MASK);
                seg.size_value = 64'h2000;
                if (seg.memory_size < 64'h2000) seg.memory_size = 64'h2000;
            end
            FLAW_BELOW_WINDOW: begin
                seg.address_value = win_lo - 64'd1 - $urandom_range(4095);
                seg.offset_value = (seg.offset_value & ~LOW12_MASK) |
                                   (seg.address_value & LOW12_MASK);
            end
            FLAW_ABOVE_WINDOW: seg.memory_size = win_hi - seg.address_value + 64'd1 +
                                                 $urandom_range(4095);
            FLAW_ADDR_WRAP: seg.memory_size = ~seg.address_value + 64'd1 +
                                              $urandom_range(1, 4095);
            FLAW_ALIGN: seg.alignment = $urandom_range(4095);
            FLAW_CONGRUENCE: seg.offset_value ^= 64'd1 << $urandom_range(11);
            default: ;
        endcase
        segs[bad_idx] = seg;

        hdr = header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, cnt,
                         HEADER_BYTES, entry, file_len);
        case (flaw)
            FLAW_IDENT: hdr.ident_bytes ^= 48'd1 << $urandom_range(47);
            FLAW_TYPE: hdr.type_code ^= 32'd1 << $urandom_range(31);
            FLAW_MACHINE: hdr.machine_code ^= 16'd1 << $urandom_range(15);
            FLAW_ENTSIZE: hdr.entry_size ^= 16'd1 << $urandom_range(15);
            FLAW_SHORT_FILE: hdr.size_value = $urandom_range(63);
            FLAW_TABLE: hdr.offset_value = file_len - 64'(cnt) * 56 + 64'd1 +
                                           $urandom_range(255);
            FLAW_TABLE_WRAP: hdr.offset_value = '1;
            FLAW_ENTRY: hdr.address_value = ($urandom_range(1) != 0) ? hi : lo - 64'd1;
            default: ;
        endcase

        if (flaw != FLAW_NO_HEADER) push_req(hdr);
        sel_idx = $urandom_range(segs.size() - 1);
        foreach (segs[k]) begin
            push_req(segs[k]);
            if (flaw == FLAW_SELECTOR && k == sel_idx) push_req(selector_req());
        end
        if (flaw != FLAW_NO_FINISH) push_req(finish_req());
        if (flaw == FLAW_EXTRA_FINISH) push_req(finish_req());
    endtask

    task automatic queue_random(int count);
        int target;
        int burst;
        target = stim_count + count;
        while (stim_count < target) begin
            if ($urandom_range(99) < 12) begin
                burst = $urandom_range(1, 3);
                repeat (burst) push_req(random_req());
            end else begin
                queue_image();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 37;
        rx_idle_pct = 46;
        queue_directed();
        wait_drained();
        write_window(WINDOW_LOW_RESET, WINDOW_HIGH_RESET);
        queue_random(330);
        wait_drained();

        tx_idle_pct = 46;
        rx_idle_pct = 37;
        write_window(64'd0, '1);
        // The loaded span ends just below the top of the address space, so
        // rounding it up to a page boundary wraps.
        push_req(header_req(IDENT_ELF64, TYPE_EXEC, MACHINE_X86_64, PHDR_BYTES, 16'd1,
                            HEADER_BYTES, 64'hffff_ffff_ffff_f800, 64'h1_0000));
        push_req(segment_req(SEG_LOAD, 64'h10, 64'hffff_ffff_ffff_f010, 64'h0, 64'hfe0,
                             64'h1000));
        push_req(finish_req());
        queue_random(250);
        wait_drained();
        write_window('1, 64'd0);
        queue_random(40);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_window(64'h1000_0000, 64'h1004_0000);
        queue_random(180);
        rx_hold_requests++;
        wait_drained();
        queue_random(180);
        wait_drained();

        repeat (8) @(negedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
